// ===== rtl/core/vwns_pkg.sv =====
// Shared types, request codes and constants of the vertex welding block.
package vwns_pkg;

	// Default sizes of the unique vertex table and of each entry's normal list.
	localparam int DEF_MAX_VERTS      = 1024;
	localparam int DEF_MAX_INFLUENCES = 4;

	// The list fill count holds up to 31 normals.
	localparam int ICNT_W = 5;

	// A normal list sum of up to 32 Q1.14 components, and the width of its divider step counter.
	localparam int SUM_W     = 21;
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	// Configuration port index width.
	localparam int CFG_IDX_W = 2;

	// Request codes.
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_DROPPED = 2'd2;
	localparam logic [1:0] STAT_RANGE   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_UV      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_NORMALS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COS           = 2'd3;

	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} normal_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic               hard_edge;
		logic [9:0]         entry_index;
	} in_item_t;

	typedef struct packed {
		logic [9:0]         out_index;
		logic               is_new;
		logic signed [15:0] avg_nx;
		logic signed [15:0] avg_ny;
		logic signed [15:0] avg_nz;
		logic [1:0]         status;
	} out_item_t;

	// One row of the unique vertex table.
	typedef struct packed {
		logic [31:0]       pos_x;
		logic [31:0]       pos_y;
		logic [31:0]       pos_z;
		logic [31:0]       uv;
		normal_t           nrm;
		logic              hard;
		logic [ICNT_W-1:0] icnt;
	} entry_t;

endpackage

// ===== rtl/core/vwns_angle.sv =====
// Multi-cycle test whether two normals lie within the cosine threshold.
module vwns_angle (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  vwns_pkg::normal_t  a,
	input  vwns_pkg::normal_t  b,
	input  logic signed [15:0] cos_thr,
	output logic               done,
	output logic               hit
);
	import vwns_pkg::*;

	localparam logic [3:0] LAST_STEP = 4'd14;

	logic               run_q;
	logic [3:0]         step_q;
	logic signed [15:0] sa;
	logic signed [15:0] sb;
	logic signed [31:0] sprod;
	logic [31:0]        ua;
	logic [31:0]        ub;
	logic [63:0]        uprod;
	logic signed [33:0] dot_q;
	logic signed [33:0] la_q;
	logic signed [33:0] lb_q;
	logic [63:0]        d2_q;
	logic [63:0]        p_q;
	logic [63:0]        lo_q;
	logic [63:0]        hi_q;
	logic [31:0]        c2_q;
	logic [33:0]        dot_mag;
	logic [15:0]        cos_mag;
	logic [95:0]        lhs;
	logic [95:0]        rhs;
	logic               ge;
	logic               le;

	assign dot_mag = dot_q[33] ? -dot_q : dot_q;
	assign cos_mag = cos_thr[15] ? -cos_thr : cos_thr;

	// Operand selection: dot product and both squared lengths first, then the wide products.
	always_comb begin
		sa = '0;
		sb = '0;
		ua = '0;
		ub = '0;
		case (step_q)
			4'd0: begin sa = a.x; sb = b.x; end
			4'd1: begin sa = a.y; sb = b.y; end
			4'd2: begin sa = a.z; sb = b.z; end
			4'd3: begin sa = a.x; sb = a.x; end
			4'd4: begin sa = a.y; sb = a.y; end
			4'd5: begin sa = a.z; sb = a.z; end
			4'd6: begin sa = b.x; sb = b.x; end
			4'd7: begin sa = b.y; sb = b.y; end
			4'd8: begin sa = b.z; sb = b.z; end
			4'd9: begin ua = dot_mag[31:0]; ub = dot_mag[31:0]; end
			4'd10: begin ua = la_q[31:0]; ub = lb_q[31:0]; end
			4'd11: begin ua = 32'(cos_mag); ub = 32'(cos_mag); end
			4'd12: begin ua = p_q[31:0]; ub = c2_q; end
			4'd13: begin ua = p_q[63:32]; ub = c2_q; end
			default: begin end
		endcase
	end

	assign sprod = sa * sb;
	assign uprod = ua * ub;

	// Step sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			if (step_q == LAST_STEP) begin
				run_q <= 1'b0;
			end
			step_q <= step_q + 4'd1;
		end
	end

	// Accumulators and product registers.
	always_ff @(posedge clk) begin
		if (run_q) begin
			case (step_q)
				4'd0: dot_q <= 34'(sprod);
				4'd1, 4'd2: dot_q <= dot_q + 34'(sprod);
				4'd3: la_q <= 34'(sprod);
				4'd4, 4'd5: la_q <= la_q + 34'(sprod);
				4'd6: lb_q <= 34'(sprod);
				4'd7, 4'd8: lb_q <= lb_q + 34'(sprod);
				4'd9: d2_q <= uprod;
				4'd10: p_q <= uprod;
				4'd11: c2_q <= uprod[31:0];
				4'd12: lo_q <= uprod;
				4'd13: hi_q <= uprod;
				default: begin end
			endcase
		end
	end

	// Compare dot squared against the product of both lengths and the squared threshold.
	assign lhs = {4'b0, d2_q, 28'b0};
	assign rhs = {hi_q, 32'b0} + {32'b0, lo_q};
	assign ge  = lhs >= rhs;
	assign le  = lhs <= rhs;

	assign done = run_q && (step_q == LAST_STEP);

	always_comb begin
		if (la_q == '0 || lb_q == '0) begin
			hit = 1'b0;
		end else if (!cos_thr[15]) begin
			hit = !dot_q[33] && ge;
		end else begin
			hit = !dot_q[33] || le;
		end
	end

endmodule

// ===== rtl/core/vwns_div.sv =====
// Bit-serial divider that averages the three summed normal components.
module vwns_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  vwns_pkg::sum_t               sums [3],
	input  logic [vwns_pkg::ICNT_W-1:0]  divisor,
	output logic                         done,
	output vwns_pkg::normal_t            avg
);
	import vwns_pkg::*;

	logic                 run_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ICNT_W-1:0]    div_q;
	logic [SUM_W-1:0]     num_q [3];
	logic [ICNT_W-1:0]    rem_q [3];
	logic                 neg_q [3];
	logic [ICNT_W:0]      rem_sh [3];
	logic                 fit [3];
	logic [SUM_W-1:0]     quo [3];

	assign done = run_q && (cnt_q == DIV_CNT_W'(SUM_W));

	// One quotient bit per lane and cycle.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_sh[i] = {rem_q[i], num_q[i][SUM_W-1]};
			fit[i]    = rem_sh[i] >= {1'b0, div_q};
			quo[i]    = neg_q[i] ? -num_q[i] : num_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= sums[i][SUM_W-1];
				num_q[i] <= sums[i][SUM_W-1] ? SUM_W'(-sums[i]) : SUM_W'(sums[i]);
				rem_q[i] <= '0;
			end
		end else if (run_q && !done) begin
			for (int i = 0; i < 3; i++) begin
				if (fit[i]) begin
					rem_q[i] <= ICNT_W'(rem_sh[i] - {1'b0, div_q});
				end else begin
					rem_q[i] <= rem_sh[i][ICNT_W-1:0];
				end
				num_q[i] <= {num_q[i][SUM_W-2:0], fit[i]};
			end
		end
	end

	assign avg.x = quo[0][15:0];
	assign avg.y = quo[1][15:0];
	assign avg.z = quo[2][15:0];

endmodule

// ===== rtl/core/vertex_weld_normal_smooth.sv =====
// Top level of the vertex welder: table memories, search sequencer and ports.
//
//   channel  direction  handshake             beat
//   in       input      in_valid / in_stall   one request (add, read, clear)
//   out      output     out_valid / out_stall one result per request
//   cfg      input      cfg_valid / cfg_ready one register write
//
// An add scans the entry table at one entry per cycle from a registered memory read; an entry
// that needs the angle test holds the scan until the test is done, and a list update reads and
// compares the stored normals one by one. A read sums the stored normals of its entry one by
// one and then averages them in the 21-step divider.
// Reset empties the table at once; no memory is swept. One request is worked at a time;
// a finished result waits in the output register while the next request is taken.
module vertex_weld_normal_smooth #(
	parameter int MAX_VERTS      = vwns_pkg::DEF_MAX_VERTS,
	parameter int MAX_INFLUENCES = vwns_pkg::DEF_MAX_INFLUENCES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  vwns_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output vwns_pkg::out_item_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vwns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import vwns_pkg::*;

	localparam int IW    = $clog2(MAX_VERTS);
	localparam int CNT_W = $clog2(MAX_VERTS + 1);
	localparam int IA_W  = $clog2(MAX_VERTS * MAX_INFLUENCES);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN    = 4'd1;
	localparam logic [3:0] S_ANGLE   = 4'd2;
	localparam logic [3:0] S_INF_RD  = 4'd3;
	localparam logic [3:0] S_INF_CMP = 4'd4;
	localparam logic [3:0] S_APPEND  = 4'd5;
	localparam logic [3:0] S_RD_ROW  = 4'd6;
	localparam logic [3:0] S_RD_WAIT = 4'd7;
	localparam logic [3:0] S_SUM_RD  = 4'd8;
	localparam logic [3:0] S_SUM_ACC = 4'd9;
	localparam logic [3:0] S_DIV     = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	// Configuration registers.
	logic               match_uv_q;
	logic               match_nrm_q;
	logic               smooth_q;
	logic signed [15:0] cos_q;

	// Control state.
	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic             v_s1;
	logic [IW-1:0]    idx_s1;
	logic [IW-1:0]    tgt_idx_q;
	logic [ICNT_W-1:0] k_q;
	logic             out_valid_q;

	// Payload registers.
	in_item_t  req_q;
	entry_t    cand_q;
	out_item_t res_q;
	out_item_t out_q;
	sum_t      sums_q [3];

	// Memories and their read data.
	entry_t  ent_mem [MAX_VERTS];
	normal_t inf_mem [MAX_VERTS * MAX_INFLUENCES];
	entry_t  row_q;
	normal_t inf_rd_q;

	// Datapath and control signals.
	normal_t   in_nrm;
	logic [31:0] in_uv;
	logic      accept;
	logic      scan_issue;
	logic      row_base;
	logic      row_same;
	logic      row_hit;
	logic      row_ang;
	logic      row_last;
	logic      grow;
	logic      full;
	logic      list_end;
	logic      list_full;
	logic      app_we;
	logic      grow_we;
	logic      ent_we;
	logic [IW-1:0] ent_raddr;
	logic [IW-1:0] ent_waddr;
	entry_t    ent_wdata;
	entry_t    new_row;
	entry_t    grow_row;
	logic [IW-1:0] ia_idx;
	logic [IA_W-1:0] ia_base;
	logic [IA_W-1:0] inf_raddr;
	logic [IA_W-1:0] inf_waddr;
	logic      ang_start;
	logic      ang_done;
	logic      ang_hit;
	logic      div_start;
	logic      div_done;
	normal_t   div_avg;
	logic      load_out;
	logic [CNT_W-1:0] tgt_next;

	// Result with zero averages.
	function automatic out_item_t mk_res(input logic [9:0] idx, input logic nw,
		input logic [1:0] st);
		out_item_t r;
		r           = '0;
		r.out_index = idx;
		r.is_new    = nw;
		r.status    = st;
		return r;
	endfunction

	assign in_nrm    = '{x: req_q.norm_x, y: req_q.norm_y, z: req_q.norm_z};
	assign in_uv     = {req_q.tex_u, req_q.tex_v};
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Entry compare on the row read in the previous cycle.
	assign scan_issue = (state_q == S_SCAN) && (rd_ptr_q < cnt_q);
	assign row_base   = !row_q.hard && !req_q.hard_edge &&
		(row_q.pos_x == req_q.pos_x) && (row_q.pos_y == req_q.pos_y) &&
		(row_q.pos_z == req_q.pos_z) && (!match_uv_q || (row_q.uv == in_uv));
	assign row_same   = (row_q.nrm == in_nrm);
	assign row_hit    = row_base && (!match_nrm_q || row_same);
	assign row_ang    = row_base && match_nrm_q && smooth_q && !row_same;
	assign row_last   = (CNT_W'(idx_s1) + CNT_W'(1)) == cnt_q;
	assign grow       = match_nrm_q && smooth_q;
	assign tgt_next   = CNT_W'(tgt_idx_q) + CNT_W'(1);

	assign full      = (cnt_q == CNT_W'(MAX_VERTS));
	assign list_end  = (k_q == cand_q.icnt);
	assign list_full = (cand_q.icnt >= ICNT_W'(MAX_INFLUENCES));
	assign app_we    = (state_q == S_APPEND) && !full;
	assign grow_we   = (state_q == S_INF_RD) && list_end && !list_full;
	assign ent_we    = app_we || grow_we;

	assign ang_start = (state_q == S_SCAN) && v_s1 && !row_hit && row_ang;
	assign div_start = (state_q == S_SUM_RD) && list_end && (cand_q.icnt != '0);
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Memory addresses and write data.
	always_comb begin
		new_row       = '0;
		new_row.pos_x = req_q.pos_x;
		new_row.pos_y = req_q.pos_y;
		new_row.pos_z = req_q.pos_z;
		new_row.uv    = in_uv;
		new_row.nrm   = in_nrm;
		new_row.hard  = req_q.hard_edge;
		new_row.icnt  = ICNT_W'(1);

		grow_row      = cand_q;
		grow_row.icnt = cand_q.icnt + ICNT_W'(1);

		ent_raddr = (state_q == S_RD_ROW) ? tgt_idx_q : rd_ptr_q[IW-1:0];
		ent_waddr = app_we ? cnt_q[IW-1:0] : tgt_idx_q;
		ent_wdata = app_we ? new_row : grow_row;

		ia_idx    = (state_q == S_APPEND) ? cnt_q[IW-1:0] : tgt_idx_q;
		ia_base   = IA_W'(ia_idx) * IA_W'(MAX_INFLUENCES);
		inf_raddr = ia_base + IA_W'(k_q);
		inf_waddr = app_we ? ia_base : ia_base + IA_W'(cand_q.icnt);
	end

	// Unique entry table.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		row_q <= ent_mem[ent_raddr];
	end

	// Normal lists, one row of slots per entry.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			inf_mem[inf_waddr] <= in_nrm;
		end
		inf_rd_q <= inf_mem[inf_raddr];
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_uv_q  <= 1'b1;
			match_nrm_q <= 1'b1;
			smooth_q    <= 1'b0;
			cos_q       <= 16'sd16384;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MATCH_UV:      match_uv_q  <= cfg_data[0];
				CFG_MATCH_NORMALS: match_nrm_q <= cfg_data[0];
				CFG_SMOOTH:        smooth_q    <= cfg_data[0];
				CFG_COS:           cos_q       <= cfg_data;
				default: begin end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_q;
		end
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_ptr_q  <= '0;
			v_s1      <= 1'b0;
			idx_s1    <= '0;
			tgt_idx_q <= '0;
			k_q       <= '0;
		end else begin
			v_s1   <= 1'b0;
			idx_s1 <= rd_ptr_q[IW-1:0];
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_data.req_type)
							REQ_ADD: begin
								rd_ptr_q <= '0;
								state_q  <= (cnt_q == '0) ? S_APPEND : S_SCAN;
							end
							REQ_READ: begin
								tgt_idx_q <= IW'(in_data.entry_index);
								if (32'(in_data.entry_index) >= 32'(cnt_q)) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD_ROW;
								end
							end
							REQ_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (v_s1 && row_hit) begin
						tgt_idx_q <= idx_s1;
						k_q       <= '0;
						state_q   <= grow ? S_INF_RD : S_DONE;
					end else if (v_s1 && row_ang) begin
						tgt_idx_q <= idx_s1;
						state_q   <= S_ANGLE;
					end else if (v_s1 && row_last) begin
						state_q <= S_APPEND;
					end else begin
						v_s1 <= scan_issue;
						if (scan_issue) begin
							rd_ptr_q <= rd_ptr_q + CNT_W'(1);
						end
					end
				end
				S_ANGLE: begin
					if (ang_done) begin
						if (ang_hit) begin
							k_q     <= '0;
							state_q <= S_INF_RD;
						end else if (tgt_next == cnt_q) begin
							state_q <= S_APPEND;
						end else begin
							rd_ptr_q <= tgt_next;
							state_q  <= S_SCAN;
						end
					end
				end
				S_INF_RD: begin
					state_q <= list_end ? S_DONE : S_INF_CMP;
				end
				S_INF_CMP: begin
					if (inf_rd_q == in_nrm) begin
						state_q <= S_DONE;
					end else begin
						k_q     <= k_q + ICNT_W'(1);
						state_q <= S_INF_RD;
					end
				end
				S_APPEND: begin
					if (!full) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_RD_ROW: state_q <= S_RD_WAIT;
				S_RD_WAIT: begin
					k_q     <= '0;
					state_q <= S_SUM_RD;
				end
				S_SUM_RD: begin
					if (!list_end) begin
						state_q <= S_SUM_ACC;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SUM_ACC: begin
					k_q     <= k_q + ICNT_W'(1);
					state_q <= S_SUM_RD;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request payload, candidate row, sums and the pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
			if (in_data.req_type == REQ_READ) begin
				res_q <= mk_res(in_data.entry_index, 1'b0,
					(32'(in_data.entry_index) >= 32'(cnt_q)) ? STAT_RANGE : STAT_OK);
			end else begin
				res_q <= mk_res('0, 1'b0, STAT_OK);
			end
		end
		if ((state_q == S_SCAN) && v_s1 && (row_hit || row_ang)) begin
			cand_q <= row_q;
			res_q  <= mk_res(10'(idx_s1), 1'b0, STAT_OK);
		end
		if ((state_q == S_INF_RD) && list_end && list_full) begin
			res_q.status <= STAT_DROPPED;
		end
		if (state_q == S_APPEND) begin
			res_q <= full ? mk_res('0, 1'b0, STAT_FULL) : mk_res(10'(cnt_q), 1'b1, STAT_OK);
		end
		if (state_q == S_RD_WAIT) begin
			cand_q <= row_q;
			for (int i = 0; i < 3; i++) begin
				sums_q[i] <= '0;
			end
		end
		if (state_q == S_SUM_ACC) begin
			sums_q[0] <= sums_q[0] + SUM_W'($signed(inf_rd_q.x));
			sums_q[1] <= sums_q[1] + SUM_W'($signed(inf_rd_q.y));
			sums_q[2] <= sums_q[2] + SUM_W'($signed(inf_rd_q.z));
		end
		if ((state_q == S_DIV) && div_done) begin
			res_q.avg_nx <= div_avg.x;
			res_q.avg_ny <= div_avg.y;
			res_q.avg_nz <= div_avg.z;
		end
	end

	vwns_angle u_angle (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ang_start),
		.a       (cand_q.nrm),
		.b       (in_nrm),
		.cos_thr (cos_q),
		.done    (ang_done),
		.hit     (ang_hit)
	);

	vwns_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sums    (sums_q),
		.divisor (cand_q.icnt),
		.done    (div_done),
		.avg     (div_avg)
	);

endmodule
